// ----- sv/sgm_pkg.sv -----
package sgm_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 10;

    // Gradient sums lie within +/-1020, the sum of squares below 2^22.
    localparam int GRAD_W = 11;
    localparam int SQ_W   = 22;
    localparam int ROOT_W = SQ_W / 2;
    localparam int REM_W  = ROOT_W + 1;

    localparam logic [CFG_W-1:0] DIM_RESET = 11'd512;
    localparam logic [CFG_W-1:0] DIM_MIN   = 11'd2;
    localparam logic [PIX_W-1:0] MAG_MAX   = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Result kinds of one item, in delivery order. Bit 0 marks the mirrored
    // bottom row, bit 1 the mirrored right column.
    localparam logic [1:0] RES_BASE     = 2'd0;
    localparam logic [1:0] RES_LAST_ROW = 2'd1;
    localparam logic [1:0] RES_LAST_COL = 2'd2;
    localparam logic [1:0] RES_CORNER   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_GRAD,
        S_SQ,
        S_SQRT,
        S_OUT
    } t_state;

endpackage

// ----- sv/sgm_isqrt.sv -----
module sgm_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sgm_pkg::SQ_W-1:0]    i_radicand,
    output logic                        o_done,
    output logic [sgm_pkg::ROOT_W-1:0]  o_root
);

    localparam int CNT_W = $clog2(sgm_pkg::ROOT_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [sgm_pkg::SQ_W-1:0]    r_rad;
    logic [sgm_pkg::REM_W-1:0]   r_rem;
    logic [sgm_pkg::ROOT_W-1:0]  r_root;

    logic [sgm_pkg::REM_W+1:0]   cand;
    logic [sgm_pkg::REM_W+1:0]   trial;
    logic [sgm_pkg::REM_W+1:0]   diff;
    logic                        ge;

    // One root bit per cycle: bring down two radicand bits and try 4*root+1.
    assign cand  = {r_rem, r_rad[sgm_pkg::SQ_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign diff  = cand - trial;
    assign ge    = (cand >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(sgm_pkg::ROOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[sgm_pkg::SQ_W-3:0], 2'b00};
            r_rem  <= ge ? diff[sgm_pkg::REM_W-1:0] : cand[sgm_pkg::REM_W-1:0];
            r_root <= {r_root[sgm_pkg::ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("square root started while busy");

endmodule

// ----- sv/sobel_gradient_magnitude.sv -----
// Each item is taken while the block is idle, then the line buffer and
// window are updated; each of the zero to four results it causes then goes
// through the gradient, square, bit-serial square root and output load, so
// a new item is taken only once its last result is loaded into the output
// register, which waits while the output is stalled. Synchronous active-low
// reset clears the counters, window and control and sets both dimensions to 512.
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH  = sgm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sgm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sgm_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [sgm_pkg::PIX_W-1:0]       i_pixel,
    input  logic                            i_frame_start,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sgm_pkg::PIX_W-1:0]       o_magnitude,
    output logic [sgm_pkg::COORD_W-1:0]     o_out_row,
    output logic [sgm_pkg::COORD_W-1:0]     o_out_col,
    output logic                            o_last,
    output logic                            o_frame_done
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int DIMW = (CW > RW) ? CW : RW;
    localparam int CMPW = ((DIMW > sgm_pkg::CFG_W) ? DIMW : sgm_pkg::CFG_W) + 1;
    localparam int PW   = sgm_pkg::PIX_W;
    localparam int GW   = sgm_pkg::GRAD_W;

    function automatic logic signed [GW:0] sx(input logic [PW-1:0] p);
        return $signed({{(GW + 1 - PW){1'b0}}, p});
    endfunction

    // Configuration
    logic [sgm_pkg::CFG_W-1:0] r_width_cfg;
    logic [sgm_pkg::CFG_W-1:0] r_height_cfg;
    logic [CMPW-1:0]           w_cfg, h_cfg, w_use, h_use;

    // Counters and per-item context
    logic [CW-1:0]   r_col, n_col, cur_c, r_c;
    logic [RW-1:0]   r_row, n_row, cur_r, r_r;
    logic [CMPW-1:0] col0, row0, col1, row1, row2, cn, rn;
    logic [PW-1:0]   r_pix;
    logic [3:0]      r_mask, n_mask;
    logic            r_top2, r_left2;
    logic [1:0]      r_idx, nxt_idx;
    logic            more;

    // Line buffers: [15:8] two rows above, [7:0] one row above.
    logic [2*PW-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PW-1:0] r_rd;

    logic [PW-1:0]   r_win [3][3];
    logic [1:0]      rmap [3];
    logic [1:0]      cmap [3];
    logic [PW-1:0]   e [3][3];
    logic signed [GW:0]   gx_w, gy_w;
    logic signed [GW-1:0] r_gx, r_gy;
    logic signed [2*GW-1:0] sqx, sqy;
    logic [sgm_pkg::SQ_W-1:0] radicand;

    logic                        sqrt_done;
    logic [sgm_pkg::ROOT_W-1:0]  sqrt_root;

    sgm_pkg::t_state r_state, n_state;
    logic accept, do_load, grad_en, sqrt_start, out_load, out_free;

    // Output register
    logic                         r_ov;
    logic [PW-1:0]                r_mag_o;
    logic [sgm_pkg::COORD_W-1:0]  r_row_o, r_col_o;
    logic                         r_last_o, r_done_o;
    logic [CMPW-1:0]              row_ext, col_ext;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= sgm_pkg::DIM_RESET;
            r_height_cfg <= sgm_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgm_pkg::CFG_IMAGE_WIDTH:  r_width_cfg  <= i_cfg_data;
                sgm_pkg::CFG_IMAGE_HEIGHT: r_height_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cfg = {{(CMPW - sgm_pkg::CFG_W){1'b0}}, r_width_cfg};
        h_cfg = {{(CMPW - sgm_pkg::CFG_W){1'b0}}, r_height_cfg};
        if (w_cfg < CMPW'(sgm_pkg::DIM_MIN))      w_use = CMPW'(sgm_pkg::DIM_MIN);
        else if (w_cfg > CMPW'(MAX_WIDTH))        w_use = CMPW'(MAX_WIDTH);
        else                                      w_use = w_cfg;
        if (h_cfg < CMPW'(sgm_pkg::DIM_MIN))      h_use = CMPW'(sgm_pkg::DIM_MIN);
        else if (h_cfg > CMPW'(MAX_HEIGHT))       h_use = CMPW'(MAX_HEIGHT);
        else                                      h_use = h_cfg;
    end

    // Position of the incoming item, and the counters after it.
    always_comb begin
        col0 = i_frame_start ? '0 : {{(CMPW - CW){1'b0}}, r_col};
        row0 = i_frame_start ? '0 : {{(CMPW - RW){1'b0}}, r_row};
        if (col0 >= w_use) begin
            col1 = '0;
            row1 = row0 + 1'b1;
        end else begin
            col1 = col0;
            row1 = row0;
        end
        row2  = (row1 >= h_use) ? '0 : row1;
        cur_c = col1[CW-1:0];
        cur_r = row2[RW-1:0];

        cn = col1 + 1'b1;
        rn = row2 + 1'b1;
        if (cn >= w_use) begin
            n_col = '0;
            n_row = (rn >= h_use) ? '0 : rn[RW-1:0];
        end else begin
            n_col = cn[CW-1:0];
            n_row = cur_r;
        end

        n_mask = 4'b0000;
        if (row2 != '0 && col1 != '0) begin
            n_mask[sgm_pkg::RES_BASE]     = 1'b1;
            n_mask[sgm_pkg::RES_LAST_ROW] = (row2 == h_use - 1'b1);
            n_mask[sgm_pkg::RES_LAST_COL] = (col1 == w_use - 1'b1);
            n_mask[sgm_pkg::RES_CORNER]   = (row2 == h_use - 1'b1) &&
                                            (col1 == w_use - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c     <= cur_c;
            r_r     <= cur_r;
            r_pix   <= i_pixel;
            r_mask  <= n_mask;
            r_top2  <= (row2 == CMPW'(1));
            r_left2 <= (col1 == CMPW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line_mem[cur_c];
        end
        if (do_load) begin
            r_line_mem[r_c] <= {r_rd[PW-1:0], r_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (do_load) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_rd[2*PW-1:PW];
            r_win[1][2] <= r_rd[PW-1:0];
            r_win[2][2] <= r_pix;
        end
    end

    // Mirrored borders become a remap of window rows and columns.
    always_comb begin
        rmap[0] = r_idx[0] ? 2'd1 : (r_top2 ? 2'd2 : 2'd0);
        rmap[1] = r_idx[0] ? 2'd2 : 2'd1;
        rmap[2] = r_idx[0] ? 2'd1 : 2'd2;
        cmap[0] = r_idx[1] ? 2'd1 : (r_left2 ? 2'd2 : 2'd0);
        cmap[1] = r_idx[1] ? 2'd2 : 2'd1;
        cmap[2] = r_idx[1] ? 2'd1 : 2'd2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                e[i][j] = r_win[rmap[i]][cmap[j]];
            end
        end
        gx_w = (sx(e[0][2]) - sx(e[0][0])) + ((sx(e[1][2]) - sx(e[1][0])) <<< 1)
             + (sx(e[2][2]) - sx(e[2][0]));
        gy_w = (sx(e[2][0]) - sx(e[0][0])) + ((sx(e[2][1]) - sx(e[0][1])) <<< 1)
             + (sx(e[2][2]) - sx(e[0][2]));
    end

    always_ff @(posedge i_clk) begin
        if (grad_en) begin
            r_gx <= gx_w[GW-1:0];
            r_gy <= gy_w[GW-1:0];
        end
    end

    assign sqx      = r_gx * r_gx;
    assign sqy      = r_gy * r_gy;
    assign radicand = $unsigned(sqx) + $unsigned(sqy);

    sgm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // Next result of this item, lowest kind above the current one.
    always_comb begin
        more    = 1'b0;
        nxt_idx = r_idx;
        for (int k = 3; k >= 0; k--) begin
            if (r_mask[k] && (k > int'(r_idx))) begin
                more    = 1'b1;
                nxt_idx = 2'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= sgm_pkg::RES_BASE;
        end else if (do_load) begin
            r_idx <= sgm_pkg::RES_BASE;
        end else if (out_load && more) begin
            r_idx <= nxt_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sgm_pkg::S_IDLE: begin
                if (accept) n_state = sgm_pkg::S_LOAD;
            end
            sgm_pkg::S_LOAD: begin
                n_state = r_mask[sgm_pkg::RES_BASE] ? sgm_pkg::S_GRAD : sgm_pkg::S_IDLE;
            end
            sgm_pkg::S_GRAD: n_state = sgm_pkg::S_SQ;
            sgm_pkg::S_SQ:   n_state = sgm_pkg::S_SQRT;
            sgm_pkg::S_SQRT: begin
                if (sqrt_done) n_state = sgm_pkg::S_OUT;
            end
            sgm_pkg::S_OUT: begin
                if (out_free) n_state = more ? sgm_pkg::S_GRAD : sgm_pkg::S_IDLE;
            end
            default: n_state = sgm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        do_load    = 1'b0;
        grad_en    = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            sgm_pkg::S_IDLE: o_in_stall = 1'b0;
            sgm_pkg::S_LOAD: do_load    = 1'b1;
            sgm_pkg::S_GRAD: grad_en    = 1'b1;
            sgm_pkg::S_SQ:   sqrt_start = 1'b1;
            sgm_pkg::S_SQRT: ;
            sgm_pkg::S_OUT:  out_load   = out_free;
            default: ;
        endcase
    end

    always_comb begin
        row_ext = {{(CMPW - RW){1'b0}}, r_r};
        col_ext = {{(CMPW - CW){1'b0}}, r_c};
        if (!r_idx[0]) row_ext = row_ext - 1'b1;
        if (!r_idx[1]) col_ext = col_ext - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_mag_o  <= (sqrt_root > sgm_pkg::ROOT_W'(sgm_pkg::MAG_MAX))
                        ? sgm_pkg::MAG_MAX : sqrt_root[PW-1:0];
            r_row_o  <= row_ext[sgm_pkg::COORD_W-1:0];
            r_col_o  <= col_ext[sgm_pkg::COORD_W-1:0];
            r_last_o <= !more;
            r_done_o <= (r_idx == sgm_pkg::RES_CORNER);
        end
    end

    assign o_out_valid  = r_ov;
    assign o_magnitude  = r_mag_o;
    assign o_out_row    = r_row_o;
    assign o_out_col    = r_col_o;
    assign o_last       = r_last_o;
    assign o_frame_done = r_done_o;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |-> !out_load)
        else $error("output item overwritten while stalled");

    a_root_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == sgm_pkg::S_SQRT))
        else $error("square root finished outside its wait state");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == sgm_pkg::S_LOAD))
        else $error("taken item not followed by line buffer update");

    a_valid_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sgm_pkg::S_GRAD) |-> r_mask[r_idx])
        else $error("result kind computed that the item does not cause");

endmodule

// ----- tb/sobel_gradient_magnitude_test.sv -----
`timescale 1ns / 1ps

module sobel_gradient_magnitude_test;

    localparam int unsigned RUN_LIMIT    = 400000;
    localparam int unsigned QUIET_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 300;

    // Pixel content styles for generated runs.
    localparam int unsigned PX_NOISE  = 0;
    localparam int unsigned PX_BINARY = 1;
    localparam int unsigned PX_MID    = 2;

    typedef struct packed {
        logic [sgm_pkg::PIX_W-1:0]   magnitude;
        logic [sgm_pkg::COORD_W-1:0] row;
        logic [sgm_pkg::COORD_W-1:0] col;
        logic                        last;
        logic                        frame_done;
    } t_mag_result;

    class t_gradient_checker;
        logic [sgm_pkg::CFG_W-1:0] width_reg;
        logic [sgm_pkg::CFG_W-1:0] height_reg;
        logic [sgm_pkg::PIX_W-1:0] line_prev [sgm_pkg::MAX_WIDTH_DEF];
        logic [sgm_pkg::PIX_W-1:0] line_prev2 [sgm_pkg::MAX_WIDTH_DEF];
        int                        win [3][3];
        int unsigned               col_pos;
        int unsigned               row_pos;
        t_mag_result               pending_mags [$];
        int unsigned               mismatches;
        int unsigned               checked;
        int unsigned               saturated;
        int unsigned               frames_done;
        int unsigned               pixels_taken;
        int unsigned               busiest;

        function new();
            width_reg    = sgm_pkg::DIM_RESET;
            height_reg   = sgm_pkg::DIM_RESET;
            col_pos      = 0;
            row_pos      = 0;
            mismatches   = 0;
            checked      = 0;
            saturated    = 0;
            frames_done  = 0;
            pixels_taken = 0;
            busiest      = 0;
            foreach (line_prev[j]) begin
                line_prev[j]  = '0;
                line_prev2[j] = '0;
            end
            foreach (win[a, b]) win[a][b] = 0;
        endfunction

        function void set_dim(logic [sgm_pkg::CFG_IDX_W-1:0] idx,
                              logic [sgm_pkg::CFG_W-1:0] val);
            if (idx == sgm_pkg::CFG_IMAGE_WIDTH) begin
                width_reg = val;
            end else begin
                height_reg = val;
            end
        endfunction

        function int unsigned dim_in_use(logic [sgm_pkg::CFG_W-1:0] raw, int unsigned hi);
            if (raw < sgm_pkg::DIM_MIN) return sgm_pkg::DIM_MIN;
            if (raw > hi) return hi;
            return raw;
        endfunction

        function int unsigned floor_root(int unsigned v);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = 2048;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (mid * mid <= v) lo = mid;
                else hi = mid;
            end
            return lo;
        endfunction

        // Window rows t/m/b and columns l/k/g select the (possibly mirrored)
        // neighborhood of the output pixel.
        function void push_mag(int t, int m, int b, int l, int k, int g,
                               int unsigned y, int unsigned x, bit done, bit is_last);
            int          gx;
            int          gy;
            int unsigned mag;
            t_mag_result r;
            gx = (win[t][g] - win[t][l]) + 2 * (win[m][g] - win[m][l])
               + (win[b][g] - win[b][l]);
            gy = (win[b][l] - win[t][l]) + 2 * (win[b][k] - win[t][k])
               + (win[b][g] - win[t][g]);
            mag = floor_root(gx * gx + gy * gy);
            if (mag > sgm_pkg::MAG_MAX) mag = sgm_pkg::MAG_MAX;
            r.magnitude  = mag[sgm_pkg::PIX_W-1:0];
            r.row        = y[sgm_pkg::COORD_W-1:0];
            r.col        = x[sgm_pkg::COORD_W-1:0];
            r.last       = is_last;
            r.frame_done = done;
            pending_mags.push_back(r);
        endfunction

        function void take_pixel(logic [sgm_pkg::PIX_W-1:0] pix, logic fs);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned n;
            int          top;
            int          left;
            int          i;
            bit          lr;
            bit          lc;
            w = dim_in_use(width_reg, sgm_pkg::MAX_WIDTH_DEF);
            h = dim_in_use(height_reg, sgm_pkg::MAX_HEIGHT_DEF);
            if (fs) begin
                col_pos = 0;
                row_pos = 0;
            end
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            c = col_pos;
            r = row_pos;
            for (i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = line_prev2[c];
            win[1][2] = line_prev[c];
            win[2][2] = pix;
            line_prev2[c] = line_prev[c];
            line_prev[c]  = pix;
            pixels_taken++;

            if (r >= 1 && c >= 1) begin
                top  = (r == 1) ? 2 : 0;
                left = (c == 1) ? 2 : 0;
                lr   = (r == h - 1);
                lc   = (c == w - 1);
                push_mag(top, 1, 2, left, 1, 2, r - 1, c - 1, 1'b0, !lr && !lc);
                if (lr) push_mag(1, 2, 1, left, 1, 2, r, c - 1, 1'b0, !lc);
                if (lc) begin
                    push_mag(top, 1, 2, 1, 2, 1, r - 1, c, 1'b0, !lr);
                    if (lr) push_mag(1, 2, 1, 1, 2, 1, r, c, 1'b1, 1'b1);
                end
                n = 1 + lr + lc + (lr && lc);
                if (n > busiest) busiest = n;
            end

            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h) row_pos = 0;
            end
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_magnitude(t_mag_result got);
            t_mag_result want;
            if (pending_mags.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: mag %0d row %0d col %0d",
                                        got.magnitude, got.row, got.col));
            end else begin
                want = pending_mags.pop_front();
                checked++;
                if (want.frame_done) frames_done++;
                if (want.magnitude == sgm_pkg::MAG_MAX) saturated++;
                if (got.magnitude !== want.magnitude || got.row !== want.row ||
                    got.col !== want.col || got.last !== want.last ||
                    got.frame_done !== want.frame_done) begin
                    flag_mismatch({
                        $sformatf("got mag %0d (%0d,%0d) last %0b done %0b, ",
                                  got.magnitude, got.row, got.col, got.last,
                                  got.frame_done),
                        $sformatf("want mag %0d (%0d,%0d) last %0b done %0b",
                                  want.magnitude, want.row, want.col, want.last,
                                  want.frame_done)});
                end
            end
        endtask
    endclass

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_we      = 1'b0;
    logic [sgm_pkg::CFG_IDX_W-1:0]     i_cfg_index   = sgm_pkg::CFG_IMAGE_WIDTH;
    logic [sgm_pkg::CFG_W-1:0]         i_cfg_data    = '0;
    logic                              i_in_valid    = 1'b0;
    logic                              o_in_stall;
    logic [sgm_pkg::PIX_W-1:0]         i_pixel       = '0;
    logic                              i_frame_start = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_stall   = 1'b0;
    logic [sgm_pkg::PIX_W-1:0]         o_magnitude;
    logic [sgm_pkg::COORD_W-1:0]       o_out_row;
    logic [sgm_pkg::COORD_W-1:0]       o_out_col;
    logic                              o_last;
    logic                              o_frame_done;

    t_gradient_checker sb;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int unsigned       hold_requests = 0;

    sobel_gradient_magnitude dut (.*);

    initial begin : clock_gen
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_pixel(input logic [sgm_pkg::PIX_W-1:0] pix, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel       <= pix;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.take_pixel(pix, fs);
    endtask

    function automatic logic [sgm_pkg::PIX_W-1:0] pixel_value(input int unsigned style);
        case (style)
            PX_NOISE:  return sgm_pkg::PIX_W'($urandom_range(255));
            PX_BINARY: return ($urandom_range(1) == 1) ? 8'd255 : 8'd0;
            default:   return sgm_pkg::PIX_W'($urandom_range(96, 160));
        endcase
    endfunction

    task automatic send_run(input int unsigned n, input logic fs_first,
                            input int unsigned style);
        int unsigned i;
        for (i = 0; i < n; i++) send_pixel(pixel_value(style), fs_first && i == 0);
    endtask

    // Returns once every predicted result has come back and the block has
    // had time to finish any item that produces nothing.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_mags.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sgm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sgm_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_dim(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_dims(input logic [sgm_pkg::CFG_W-1:0] w,
                              input logic [sgm_pkg::CFG_W-1:0] h);
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    // Small frames of fixed size; most are complete, some are cut short by a
    // new frame start and some run on into the next frame without one.
    task automatic random_phase(input int unsigned n_items, input bit with_hold);
        int unsigned cw;
        int unsigned ch;
        int unsigned raw_w;
        int unsigned raw_h;
        int unsigned area;
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        settle();
        cw    = $urandom_range(2, 6);
        ch    = $urandom_range(2, 4);
        raw_w = cw;
        raw_h = ch;
        if (cw == 2 && $urandom_range(1) == 1) raw_w = $urandom_range(1);
        if (ch == 2 && $urandom_range(1) == 1) raw_h = $urandom_range(1);
        write_dims(raw_w[sgm_pkg::CFG_W-1:0], raw_h[sgm_pkg::CFG_W-1:0]);
        if (with_hold) hold_requests++;
        area = cw * ch;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 75) len = area;
            else if (pick < 90) len = $urandom_range(1, area - 1);
            else len = area + $urandom_range(1, 2 * cw);
            send_run(len, 1'b1, $urandom_range(PX_MID));
            sent += len;
        end
    endtask

    initial begin : result_sink
        int unsigned hold_left;
        int unsigned hold_served;
        t_mag_result got;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.magnitude  = o_magnitude;
                got.row        = o_out_row;
                got.col        = o_out_col;
                got.last       = o_last;
                got.frame_done = o_frame_done;
                sb.check_magnitude(got);
            end
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles_run;
        cycles_run = 0;
        while (cycles_run < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycles_run, sb.pending_mags.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int unsigned i;
        int unsigned mode;
        int unsigned k;
        sb = new();
        send_idle_pct = 18;
        recv_idle_pct = 45;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset dimensions: a few pixels along the first row cause no result.
        send_run(6, 1'b1, PX_NOISE);

        // Width and height below the minimum give a 2x2 frame, four results
        // from the corner pixel; the second frame starts by wrap-around.
        settle();
        write_dims(11'd0, 11'd1);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_run(4, 1'b0, PX_BINARY);

        // Hard vertical edge drives the magnitude into saturation.
        settle();
        write_dims(11'd4, 11'd3);
        for (i = 0; i < 12; i++) send_pixel((i % 4 >= 2) ? 8'd255 : 8'd0, i == 0);
        for (i = 0; i < 3; i++) send_pixel(pixel_value(PX_NOISE), 1'b1);

        // Oversized width clamps to the maximum line length; a short run
        // stays within the first row.
        settle();
        write_dims(11'd2047, 11'd0);
        send_run(6, 1'b1, PX_NOISE);

        // Oversized height: no row counts as the last one.
        settle();
        write_dims(11'd3, 11'd2047);
        send_run(12, 1'b1, PX_MID);

        // Shrink the frame while a frame is in progress: the column and then
        // the row counter land beyond the new size and wrap.
        settle();
        write_dims(11'd6, 11'd5);
        send_run(16, 1'b1, PX_NOISE);
        settle();
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, 11'd4);
        send_run(18, 1'b0, PX_NOISE);
        settle();
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 11'd2);
        send_run(6, 1'b0, PX_BINARY);

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (k = 0; k < 2; k++) random_phase(12, mode == 2 && k == 0);
        end

        settle();
        $display("Streamed %0d pixels through small, clamped and resized frames,",
                 sb.pixels_taken);
        $display("checked %0d results (%0d saturated, %0d frame ends, up to %0d per pixel).",
                 sb.checked, sb.saturated, sb.frames_done, sb.busiest);
        if (sb.mismatches == 0 && sb.pending_mags.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/sgm_pkg.sv
sv/sgm_isqrt.sv
sv/sobel_gradient_magnitude.sv
tb/sobel_gradient_magnitude_test.sv
